// ----- src/ipv4_forward_header_update_unit_macros.svh -----
// Assertion macros used by the checker module ipv4fhu_chk.
`ifndef IPV4_FORWARD_HEADER_UPDATE_UNIT_MACROS_SVH
`define IPV4_FORWARD_HEADER_UPDATE_UNIT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define FHU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A signal must hold while the output item is stalled.
`define FHU_ASSERT_HOLD(label, sig, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(sig)) else $error(msg);

`endif

// ----- src/ipv4fhu_pkg.sv -----
package ipv4fhu_pkg;

    localparam int DEF_MAX_HDR_BYTES = 60;
    localparam int CNT_W             = 6;

    localparam logic [3:0]       MIN_IHL    = 4'd5;
    localparam logic [CNT_W-1:0] POS_TTL    = 6'd8;
    localparam logic [CNT_W-1:0] POS_CKS_HI = 6'd10;
    localparam logic [CNT_W-1:0] POS_CKS_LO = 6'd11;

    typedef struct packed {
        logic recv_en;
        logic send_start;
        logic send_en;
        logic load_bad;
    } t_cmd;

    typedef struct packed {
        logic in_final;
        logic match;
        logic send_done;
        logic out_free;
    } t_sts;

    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'b0, t[16]};
    endfunction

endpackage

// ----- src/ipv4fhu_ram.sv -----
module ipv4fhu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ipv4fhu_ctrl.sv -----
module ipv4fhu_ctrl import ipv4fhu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_RECV  = 3'b001,
        ST_CHECK = 3'b010,
        ST_SEND  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_RECV: begin
                o_cmd.recv_en = 1'b1;
                if (i_sts.in_final) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.match) begin
                    o_cmd.send_start = 1'b1;
                    n_state          = ST_SEND;
                end else if (i_sts.out_free) begin
                    o_cmd.load_bad = 1'b1;
                    n_state        = ST_RECV;
                end
            end
            ST_SEND: begin
                o_cmd.send_en = 1'b1;
                if (i_sts.send_done) begin
                    n_state = ST_RECV;
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RECV;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/ipv4fhu_dp.sv -----
module ipv4fhu_dp import ipv4fhu_pkg::*; #(
    parameter int MAX_HEADER_BYTES = DEF_MAX_HDR_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_ok,
    output logic       o_out_last
);

    localparam int               AW      = $clog2(MAX_HEADER_BYTES);
    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_HEADER_BYTES);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_len;
    logic [15:0]      r_sum;
    logic [15:0]      r_sum2;
    logic [15:0]      r_rcv;
    logic [15:0]      r_new_cks;
    logic [CNT_W-1:0] r_issue_idx;
    logic             r_rd_vld;
    logic [CNT_W-1:0] r_tag_idx;
    logic             r_tag_last;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_ok;
    logic             r_out_last;

    logic             accept;
    logic [3:0]       ihl_fix;
    logic [CNT_W-1:0] len_raw;
    logic [CNT_W-1:0] len_cur;
    logic             is_final;
    logic             is_cks;
    logic [7:0]       byte_adj;
    logic [15:0]      sum_base;
    logic [15:0]      sum2_base;
    logic [15:0]      w1;
    logic [15:0]      w2;
    logic [15:0]      n_sum;
    logic [15:0]      n_sum2;
    logic             slot_free;
    logic             load;
    logic             issue;
    logic             issue_last;
    logic [7:0]       ram_rdata;
    logic [7:0]       sub_byte;

    assign accept   = i_in_valid && i_cmd.recv_en;
    assign ihl_fix  = (i_in_byte[3:0] < MIN_IHL) ? MIN_IHL : i_in_byte[3:0];
    assign len_raw  = {ihl_fix, 2'b00};
    assign len_cur  = (r_cnt != '0) ? r_len : ((len_raw > MAX_LEN) ? MAX_LEN : len_raw);
    assign is_final = ({1'b0, r_cnt} + 1'b1) == {1'b0, len_cur};
    assign is_cks   = (r_cnt == POS_CKS_HI) || (r_cnt == POS_CKS_LO);
    assign byte_adj = (r_cnt == POS_TTL) ? (i_in_byte - 8'd1) : i_in_byte;

    assign sum_base  = (r_cnt == '0) ? 16'h0000 : r_sum;
    assign sum2_base = (r_cnt == '0) ? 16'h0000 : r_sum2;
    assign w1        = r_cnt[0] ? {8'h00, i_in_byte} : {i_in_byte, 8'h00};
    assign w2        = r_cnt[0] ? {8'h00, byte_adj} : {byte_adj, 8'h00};
    assign n_sum     = is_cks ? sum_base : fold_add(sum_base, w1);
    assign n_sum2    = (is_cks || (is_final && !r_cnt[0])) ? sum2_base
                                                            : fold_add(sum2_base, w2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_len <= '0;
        end else if (accept) begin
            r_cnt <= is_final ? '0 : (r_cnt + 1'b1);
            r_len <= len_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum  <= n_sum;
            r_sum2 <= n_sum2;
            if (r_cnt == POS_CKS_HI) begin
                r_rcv[15:8] <= i_in_byte;
            end
            if (r_cnt == POS_CKS_LO) begin
                r_rcv[7:0] <= i_in_byte;
            end
        end
        if (i_cmd.send_start) begin
            r_new_cks <= ~r_sum2;
        end
    end

    assign slot_free  = !r_out_valid || i_out_ready;
    assign load       = r_rd_vld && slot_free;
    assign issue      = i_cmd.send_en && (!r_rd_vld || load);
    assign issue_last = ({1'b0, r_issue_idx} + 1'b1) == {1'b0, r_len};

    ipv4fhu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_HEADER_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (byte_adj),
        .i_re    (issue),
        .i_raddr (r_issue_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        sub_byte = ram_rdata;
        if (r_tag_idx == POS_CKS_HI) begin
            sub_byte = r_new_cks[15:8];
        end else if (r_tag_idx == POS_CKS_LO) begin
            sub_byte = r_new_cks[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_idx <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.send_start) begin
                r_issue_idx <= '0;
            end else if (issue) begin
                r_issue_idx <= r_issue_idx + 1'b1;
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (load) begin
                r_rd_vld <= 1'b0;
            end
            if (load || i_cmd.load_bad) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_tag_idx  <= r_issue_idx;
            r_tag_last <= issue_last;
        end
        if (load) begin
            r_out_byte <= sub_byte;
            r_out_ok   <= 1'b1;
            r_out_last <= r_tag_last;
        end else if (i_cmd.load_bad) begin
            r_out_byte <= 8'h00;
            r_out_ok   <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    assign o_sts.in_final  = accept && is_final;
    assign o_sts.match     = (~r_sum) == r_rcv;
    assign o_sts.send_done = issue && issue_last;
    assign o_sts.out_free  = !r_rd_vld && slot_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_ok    = r_out_ok;
    assign o_out_last  = r_out_last;

endmodule

// ----- src/ipv4_forward_header_update_unit.sv -----
// Timing: each header is followed by the check state. A good header's first item passes
// the header RAM read register, then the output register; a rejection item is loaded
// into the output register once it is free. Output: one byte per cycle from the RAM read
// port while the receiver is ready. Input waits until the last output byte is issued.
// Reset: synchronous, active low; clears the controller, byte counter and output
// valid. Stored header bytes are not cleared.
module ipv4_forward_header_update_unit import ipv4fhu_pkg::*; #(
    parameter int MAX_HEADER_BYTES = DEF_MAX_HDR_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] header_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] o_m_axis_tuser,   // [0] checksum_ok
    output logic       o_m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    ipv4fhu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ipv4fhu_dp #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_byte   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_ok    (o_m_axis_tuser[0]),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_s_axis_tready = cmd.recv_en;

endmodule

// ----- src/ipv4fhu_chk.sv -----
`include "ipv4_forward_header_update_unit_macros.svh"

module ipv4fhu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [0:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    `FHU_ASSERT(a_reject_form, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 8'h00 && o_m_axis_tlast, "Rejected item is not a single zero item.")
    `FHU_ASSERT(a_no_reject_midburst, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[0] && !o_m_axis_tlast |=> !(o_m_axis_tvalid && !o_m_axis_tuser[0]), "Rejection inside a header burst.")
    `FHU_ASSERT_HOLD(a_hold_valid, o_m_axis_tvalid, "Output valid dropped while stalled.")
    `FHU_ASSERT_HOLD(a_hold_data, o_m_axis_tdata, "Output data changed while stalled.")

endmodule

bind ipv4_forward_header_update_unit ipv4fhu_chk u_chk (.*);

// ----- test/ipv4_header_update_checker.sv -----
`timescale 1ns / 100ps

module ipv4_header_update_checker import ipv4fhu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] header_byte
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [7:0] out_byte
    input  logic [0:0] i_m_axis_tuser,   // [0] checksum_ok
    input  logic       i_m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       ok;
        logic       last;
    } t_hdr_result;

    t_hdr_result expected_results[$];
    logic [7:0]  hdr_copy [0:DEF_MAX_HDR_BYTES-1];
    int          rx_pos     = 0;
    int          hdr_len    = 0;
    logic [15:0] word_sum   = '0;
    logic [15:0] rx_csum    = '0;
    int          fail_total = 0;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] acc;
        acc = {1'b0, a} + {1'b0, b};
        return acc[15:0] + {15'b0, acc[16]};
    endfunction

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Accumulates one header byte and queues the output of a completed header.
    task automatic predict_byte(input logic [7:0] b);
        int          ihl;
        int          pos;
        logic [15:0] csum;
        t_hdr_result res;
        if (rx_pos == 0) begin
            ihl = int'(b[3:0]);
            if (ihl < int'(MIN_IHL)) begin
                ihl = int'(MIN_IHL);
            end
            hdr_len  = (ihl * 4 > DEF_MAX_HDR_BYTES) ? DEF_MAX_HDR_BYTES : ihl * 4;
            word_sum = '0;
            rx_csum  = '0;
        end
        pos = (rx_pos >= DEF_MAX_HDR_BYTES) ? DEF_MAX_HDR_BYTES - 1 : rx_pos;
        hdr_copy[pos] = b;
        if (pos == int'(POS_CKS_HI)) begin
            rx_csum[15:8] = b;
        end else if (pos == int'(POS_CKS_LO)) begin
            rx_csum[7:0] = b;
        end else if (pos % 2 == 1) begin
            word_sum = ones_add(word_sum, {8'h00, b});
        end else begin
            word_sum = ones_add(word_sum, {b, 8'h00});
        end
        if (pos + 1 < hdr_len) begin
            rx_pos = pos + 1;
        end else begin
            rx_pos = 0;
            csum   = ~word_sum;
            if (csum != rx_csum) begin
                res = '{data: 8'h00, ok: 1'b0, last: 1'b1};
                expected_results.push_back(res);
            end else begin
                hdr_copy[POS_TTL]    = hdr_copy[POS_TTL] - 8'd1;
                hdr_copy[POS_CKS_HI] = 8'h00;
                hdr_copy[POS_CKS_LO] = 8'h00;
                csum = '0;
                for (int i = 0; i + 1 < hdr_len; i += 2) begin
                    csum = ones_add(csum, {hdr_copy[i], hdr_copy[i+1]});
                end
                csum = ~csum;
                hdr_copy[POS_CKS_HI] = csum[15:8];
                hdr_copy[POS_CKS_LO] = csum[7:0];
                for (int i = 0; i < hdr_len; i++) begin
                    res.data = hdr_copy[i];
                    res.ok   = 1'b1;
                    res.last = (i == hdr_len - 1);
                    expected_results.push_back(res);
                end
            end
        end
    endtask

    task automatic check_result();
        t_hdr_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item data=%02h ok=%0b last=%0b",
                i_m_axis_tdata, i_m_axis_tuser[0], i_m_axis_tlast));
        end else begin
            want = expected_results.pop_front();
            if (i_m_axis_tdata !== want.data) begin
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                    i_m_axis_tdata, want.data));
            end
            if (i_m_axis_tuser[0] !== want.ok) begin
                report_mismatch($sformatf("checksum_ok %0b, expected %0b",
                    i_m_axis_tuser[0], want.ok));
            end
            if (i_m_axis_tlast !== want.last) begin
                report_mismatch($sformatf("last %0b, expected %0b",
                    i_m_axis_tlast, want.last));
            end
        end
    endtask

    // Outputs are checked before inputs so that a header completed at this
    // edge cannot supply the expectation for an item leaving at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_pos   = 0;
            hdr_len  = 0;
            word_sum = '0;
            rx_csum  = '0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                check_result();
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_byte(i_s_axis_tdata);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

// ----- test/ipv4_forward_header_update_unit_tb.sv -----
`timescale 1ns / 100ps

module ipv4_forward_header_update_unit_tb;
    import ipv4fhu_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] header_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;   // [7:0] out_byte
    logic [0:0] o_m_axis_tuser;   // [0] checksum_ok
    logic       o_m_axis_tlast;

    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_on    = 1'b0;
    int   hold_count     = 0;
    int   quiet_cycles   = 0;
    int   bytes_sent     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ipv4_forward_header_update_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    ipv4_header_update_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .i_m_axis_tuser (o_m_axis_tuser),
        .i_m_axis_tlast (o_m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Once pressure is requested, the receiver holds off for a fixed stretch.
    always @(posedge i_clk) begin
        if (pressure_on && hold_count < HOLD_CYCLES) begin
            hold_count      <= hold_count + 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    // Builds a header with a correct checksum, or a corrupted one when good is 0.
    task automatic send_header(input logic [7:0] first, input logic [7:0] ttl,
                               input bit good, input t_fill fill);
        logic [7:0]  hdr [0:DEF_MAX_HDR_BYTES-1];
        int          ihl;
        int          len;
        logic [16:0] acc;
        logic [15:0] sum;
        ihl = int'(first[3:0]);
        if (ihl < int'(MIN_IHL)) begin
            ihl = int'(MIN_IHL);
        end
        len    = ihl * 4;
        hdr[0] = first;
        for (int i = 1; i < len; i++) begin
            case (fill)
                FILL_ZERO: hdr[i] = 8'h00;
                FILL_ONES: hdr[i] = 8'hFF;
                default:   hdr[i] = 8'($urandom);
            endcase
        end
        hdr[POS_TTL]    = ttl;
        hdr[POS_CKS_HI] = 8'h00;
        hdr[POS_CKS_LO] = 8'h00;
        sum = '0;
        for (int i = 0; i < len; i += 2) begin
            acc = {1'b0, sum} + {1'b0, hdr[i], hdr[i+1]};
            sum = acc[15:0] + {15'b0, acc[16]};
        end
        sum = ~sum;
        if (!good) begin
            sum = sum ^ 16'($urandom_range(65535, 1));
        end
        hdr[POS_CKS_HI] = sum[15:8];
        hdr[POS_CKS_LO] = sum[7:0];
        for (int i = 0; i < len; i++) begin
            send_byte(hdr[i]);
        end
    endtask

    // Mostly short headers; about one in five carries a bad checksum.
    task automatic send_random_headers(input int n_bytes);
        int         stop_at;
        logic [3:0] ihl;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            ihl = ($urandom_range(9) < 7) ? 4'($urandom_range(5)) : 4'($urandom_range(15, 6));
            send_header({4'($urandom), ihl}, 8'($urandom), $urandom_range(99) < 80, FILL_RANDOM);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_header(8'h00, 8'h00, 1'b1, FILL_ZERO);
        send_header(8'hF4, 8'hFF, 1'b1, FILL_ONES);
        send_header(8'h45, 8'h40, 1'b0, FILL_RANDOM);
        send_header(8'hFF, 8'h01, 1'b1, FILL_RANDOM);

        send_random_headers(40);
        send_idle_pct = 49;
        send_random_headers(40);
        send_idle_pct = 0;
        recv_stall_pct <= 49;
        send_random_headers(40);
        send_idle_pct = 28;
        recv_stall_pct <= 28;
        send_random_headers(40);
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        pressure_on    <= 1'b1;
        send_random_headers(60);
        i_s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
